>>> design/b64d_pkg.sv
// Shared types, character codes and the character classifier for the base64 decoder.
package b64d_pkg;

    // One input beat: a character of the encoded text
    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_final;
    } in_item_t;

    // One result beat: a decoded byte or an error report
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
        logic       end_of_string;
        logic       error;
    } out_item_t;

    // Work handed from the front end to the back end: one closed group or one error
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        fin;
        logic        err;
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_PAD,
        KIND_BAD
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [5:0] value;
    } char_class_t;

    localparam logic [7:0] ASCII_UC_A  = 8'h41;
    localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
    localparam logic [7:0] ASCII_LC_A  = 8'h61;
    localparam logic [7:0] ASCII_LC_Z  = 8'h7A;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_UNDER = 8'h5F;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;
    localparam logic [7:0] ASCII_EQUAL = 8'h3D;

    localparam logic [7:0] LC_BASE     = 8'd26;
    localparam logic [7:0] DIGIT_BASE  = 8'd52;
    localparam logic [5:0] VAL_62      = 6'd62;
    localparam logic [5:0] VAL_63      = 6'd63;

    // Map a character to its 6-bit value, a pad, or invalid
    function automatic char_class_t classify(input logic [7:0] ch);
        char_class_t c;
        c.kind  = KIND_BAD;
        c.value = 6'd0;
        priority if (ch >= ASCII_UC_A && ch <= ASCII_UC_Z)
        begin
            c.kind  = KIND_DATA;
            c.value = 6'(ch - ASCII_UC_A);
        end
        else if (ch >= ASCII_LC_A && ch <= ASCII_LC_Z)
        begin
            c.kind  = KIND_DATA;
            c.value = 6'(ch - ASCII_LC_A + LC_BASE);
        end
        else if (ch >= ASCII_ZERO && ch <= ASCII_NINE)
        begin
            c.kind  = KIND_DATA;
            c.value = 6'(ch - ASCII_ZERO + DIGIT_BASE);
        end
        else if (ch == ASCII_MINUS || ch == ASCII_PLUS)
        begin
            c.kind  = KIND_DATA;
            c.value = VAL_62;
        end
        else if (ch == ASCII_UNDER || ch == ASCII_SLASH)
        begin
            c.kind  = KIND_DATA;
            c.value = VAL_63;
        end
        else if (ch == ASCII_EQUAL)
        begin
            c.kind  = KIND_PAD;
        end
        else
        begin
            // not in either alphabet
            c.kind  = KIND_BAD;
        end
        return c;
    endfunction

endpackage

>>> design/b64d_front.sv
// Front end: classify characters, gather groups, and queue closed groups or errors.
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  b64d_pkg::in_item_t item,
    output logic              cmd_push,
    output b64d_pkg::cmd_t    cmd
);

    logic [17:0] group_bits_reg,  group_bits_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic [2:0]  pad_count_reg,   pad_count_next;
    logic        discarding_reg,  discarding_next;

    b64d_pkg::char_class_t cls;
    logic [23:0] word;
    logic [23:0] closed_word;
    logic [2:0]  pads;
    logic [2:0]  pads_total;

    assign cls = b64d_pkg::classify(item.char_byte);

    // Build the group word and close it with implicit pads if the string ends early
    always_comb
    begin
        word = {group_bits_reg, (cls.kind == b64d_pkg::KIND_PAD) ? 6'd0 : cls.value};
        pads = pad_count_reg + ((cls.kind == b64d_pkg::KIND_PAD) ? 3'd1 : 3'd0);
        unique case (group_count_reg)
            2'd0:
            begin
                closed_word = word << 18;
                pads_total  = pads + 3'd3;
            end
            2'd1:
            begin
                closed_word = word << 12;
                pads_total  = pads + 3'd2;
            end
            2'd2:
            begin
                closed_word = word << 6;
                pads_total  = pads + 3'd1;
            end
            default:
            begin
                closed_word = word;
                pads_total  = pads;
            end
        endcase
    end

    // Advance group state and issue work to the queue
    always_comb
    begin
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        pad_count_next   = pad_count_reg;
        discarding_next  = discarding_reg;
        cmd_push         = 1'b0;
        cmd.word         = closed_word;
        cmd.nbytes       = (pads_total == 3'd0) ? 2'd3 : (pads_total == 3'd1) ? 2'd2 : 2'd1;
        cmd.fin          = item.is_final;
        cmd.err          = 1'b0;
        if (accept)
        begin
            priority if (discarding_reg)
            begin
                // drop input until the end of the string
                if (item.is_final)
                begin
                    discarding_next = 1'b0;
                end
            end
            else if (cls.kind == b64d_pkg::KIND_BAD)
            begin
                cmd_push         = 1'b1;
                cmd.word         = 24'd0;
                cmd.nbytes       = 2'd1;
                cmd.err          = 1'b1;
                group_bits_next  = 18'd0;
                group_count_next = 2'd0;
                pad_count_next   = 3'd0;
                discarding_next  = !item.is_final;
            end
            else if (group_count_reg != 2'd3 && !item.is_final)
            begin
                group_bits_next  = word[17:0];
                group_count_next = group_count_reg + 2'd1;
                pad_count_next   = pads;
            end
            else
            begin
                cmd_push         = 1'b1;
                group_bits_next  = 18'd0;
                group_count_next = 2'd0;
                pad_count_next   = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg  <= 18'd0;
            group_count_reg <= 2'd0;
            pad_count_reg   <= 3'd0;
            discarding_reg  <= 1'b0;
        end
        else
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            pad_count_reg   <= pad_count_next;
            discarding_reg  <= discarding_next;
        end
    end

endmodule

>>> design/b64d_fifo.sv
// Short queue of group commands between the front end and the back end.
module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::cmd_t push_cmd,
    input  logic           pop,
    output b64d_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/b64d_back.sv
// Back end: split each queued command into result beats held in an output register.
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64d_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output b64d_pkg::out_item_t result,
    output logic                empty,
    input  logic                pop
);

    logic                out_valid_reg, out_valid_next;
    b64d_pkg::out_item_t out_reg,       out_next;
    logic [1:0]          idx_reg,       idx_next;
    logic                load;
    logic                last_byte;

    assign load      = !cmd_empty && (!out_valid_reg || pop);
    assign last_byte = (idx_reg == cmd.nbytes - 2'd1);
    assign cmd_pop   = load && last_byte;
    assign result    = out_reg;
    assign empty     = !out_valid_reg;

    // Pick the next byte of the head command
    always_comb
    begin
        out_next               = out_reg;
        out_valid_next         = out_valid_reg;
        idx_next               = idx_reg;
        out_next.last_of_run   = last_byte;
        out_next.end_of_string = last_byte && cmd.fin;
        out_next.error         = cmd.err;
        unique case (idx_reg)
            2'd0:    out_next.data_byte = cmd.word[23:16];
            2'd1:    out_next.data_byte = cmd.word[15:8];
            default: out_next.data_byte = cmd.word[7:0];
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last_byte ? 2'd0 : idx_reg + 2'd1;
        end
        else
        begin
            out_next = out_reg;
            if (pop)
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

>>> design/base64url_stream_decoder.sv
// Top level of the streaming base64 / base64url decoder.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | item   : char_byte, is_final
//  result   | pop / empty        | result : data_byte, last_of_run,
//           |                    |          end_of_string, error
//
// One character is taken per cycle while the command queue is not full; the
// front end closes a group in the cycle it takes the fourth (or final)
// character and queues it. The back end emits one byte per cycle from the
// queue head into the output register while results are popped, so a full
// group of 3 bytes per 4 characters keeps pace. The first byte of a group
// is written to the queue, then loaded into the output register.
// full rises only when the command queue (CMD_DEPTH entries) is full.
// Reset clears the group state, the queue and the output valid flag.
module base64url_stream_decoder #(
    parameter int CMD_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::out_item_t result
);

    logic           cmd_push;
    b64d_pkg::cmd_t cmd_in;
    b64d_pkg::cmd_t cmd_head;
    logic           cmd_empty;
    logic           cmd_full;
    logic           cmd_pop;

    assign full = cmd_full;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (push && !cmd_full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    b64d_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .pop      (cmd_pop),
        .head     (cmd_head),
        .empty    (cmd_empty),
        .full     (cmd_full)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

>>> design/b64d_checker.sv
// Port-level checks for the base64 decoder, bound to the top level.
module b64d_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input b64d_pkg::in_item_t  item,
    input logic                empty,
    input logic                pop,
    input b64d_pkg::out_item_t result
);

    // Show no result beat while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result beat shown during reset");

    // Hold a stalled input beat until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |=> (push && $stable(item)))
        else $error("stalled input beat changed");

    // Report an error as a single zero byte that ends its run
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.error) |-> (result.data_byte == 8'd0 && result.last_of_run))
        else $error("error beat not a zero byte ending its run");

    // End a string only on the last beat of a run
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.end_of_string) |-> result.last_of_run)
        else $error("end_of_string without last_of_run");

    // Hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result beat changed");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

>>> dv/base64url_stream_decoder_test.sv
// Self-checking testbench for the streaming base64 / base64url decoder.
`timescale 1ns / 100ps

module base64url_stream_decoder_test;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_CHARS = 275;

    // Tracks the decoder's group state and the bytes it still owes
    class decode_tracker;
        logic [17:0]         group_bits;
        logic [1:0]          group_count;
        logic [2:0]          pad_count;
        logic                discarding;
        b64d_pkg::out_item_t due_bytes[$];
        int                  mismatches;

        function new();
            group_bits  = '0;
            group_count = '0;
            pad_count   = '0;
            discarding  = 1'b0;
            mismatches  = 0;
        endfunction

        // Value of a character in either alphabet, -1 when invalid
        function int sextet(logic [7:0] ch);
            if (ch >= b64d_pkg::ASCII_UC_A && ch <= b64d_pkg::ASCII_UC_Z)
                return int'(ch - b64d_pkg::ASCII_UC_A);
            if (ch >= b64d_pkg::ASCII_LC_A && ch <= b64d_pkg::ASCII_LC_Z)
                return int'(ch - b64d_pkg::ASCII_LC_A) + 26;
            if (ch >= b64d_pkg::ASCII_ZERO && ch <= b64d_pkg::ASCII_NINE)
                return int'(ch - b64d_pkg::ASCII_ZERO) + 52;
            if (ch == b64d_pkg::ASCII_MINUS || ch == b64d_pkg::ASCII_PLUS)
                return 62;
            if (ch == b64d_pkg::ASCII_UNDER || ch == b64d_pkg::ASCII_SLASH)
                return 63;
            return -1;
        endfunction

        function void clear_group();
            group_bits  = '0;
            group_count = '0;
            pad_count   = '0;
        endfunction

        // Advance the group state on one accepted character beat
        function void note_char(b64d_pkg::in_item_t c);
            int                  val;
            int                  held;
            int                  pads;
            int                  nbytes;
            logic [23:0]         word;
            b64d_pkg::out_item_t r;

            if (discarding)
            begin
                if (c.is_final)
                    discarding = 1'b0;
                return;
            end

            if (c.char_byte == b64d_pkg::ASCII_EQUAL)
            begin
                val  = 0;
                pads = pad_count + 1;
            end
            else
            begin
                val = sextet(c.char_byte);
                if (val < 0)
                begin
                    // invalid character: one error beat, then drop to end of string
                    clear_group();
                    discarding      = !c.is_final;
                    r.data_byte     = 8'h00;
                    r.last_of_run   = 1'b1;
                    r.end_of_string = c.is_final;
                    r.error         = 1'b1;
                    due_bytes.push_back(r);
                    return;
                end
                pads = pad_count;
            end

            held = group_count + 1;
            word = {group_bits, 6'(val)};
            if (held < 4 && !c.is_final)
            begin
                group_bits  = word[17:0];
                group_count = 2'(held);
                pad_count   = 3'(pads);
                return;
            end

            // close the group; a short final group is padded out
            while (held < 4)
            begin
                word = word << 6;
                pads++;
                held++;
            end
            nbytes = (pads >= 2) ? 1 : ((pads == 1) ? 2 : 3);
            for (int k = 0; k < nbytes; k++)
            begin
                r.data_byte     = 8'(word >> (16 - 8 * k));
                r.last_of_run   = (k == nbytes - 1);
                r.end_of_string = (k == nbytes - 1) && c.is_final;
                r.error         = 1'b0;
                due_bytes.push_back(r);
            end
            clear_group();
        endfunction

        // Compare one accepted result beat with the oldest owed byte
        function void check_byte(b64d_pkg::out_item_t got);
            b64d_pkg::out_item_t want;
            if (due_bytes.size() == 0)
            begin
                $error("unexpected result: data_byte %0h error %0b", got.data_byte, got.error);
                mismatches++;
                return;
            end
            want = due_bytes.pop_front();
            if (got.data_byte !== want.data_byte)
            begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                mismatches++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
                mismatches++;
            end
            if (got.end_of_string !== want.end_of_string)
            begin
                $error("end_of_string: expected %0b, got %0b",
                       want.end_of_string, got.end_of_string);
                mismatches++;
            end
            if (got.error !== want.error)
            begin
                $error("error: expected %0b, got %0b", want.error, got.error);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk   = 1'b0;
    logic                rst_n;
    logic                push  = 1'b0;
    logic                full;
    b64d_pkg::in_item_t  item  = '0;
    logic                empty;
    logic                pop   = 1'b0;
    b64d_pkg::out_item_t result;

    decode_tracker      tracker = new();
    b64d_pkg::in_item_t char_beats[$];
    int                 idle_cycles = 0;
    logic [7:0]         pop_mask    = 8'hFF;
    int                 mask_left   = 0;
    int                 mask_pos    = 0;

    base64url_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #6 clk = ~clk;

    // Observe accepted beats on both sides and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                tracker.note_char(item);
            if (pop && !empty)
                tracker.check_byte(result);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("base64url_stream_decoder_test: errors");
                $finish;
            end
        end
    end

    // Stall the result side on a rotating mask that changes now and then
    always @(posedge clk)
    begin
        if (mask_left == 0)
        begin
            pop_mask  = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            mask_left = $urandom_range(16, 96);
        end
        mask_left--;
        pop      <= pop_mask[mask_pos];
        mask_pos = (mask_pos + 1) % 8;
    end

    // Queue a literal string, final flag on its last character if asked
    task automatic queue_text(string s, bit ends_string);
        b64d_pkg::in_item_t c;
        for (int i = 0; i < s.len(); i++)
        begin
            c.char_byte = s[i];
            c.is_final  = ends_string && (i == s.len() - 1);
            char_beats.push_back(c);
        end
    endtask

    task automatic queue_raw(logic [7:0] ch, bit fin);
        b64d_pkg::in_item_t c;
        c.char_byte = ch;
        c.is_final  = fin;
        char_beats.push_back(c);
    endtask

    // Character for a 6-bit value, either alphabet for 62 and 63
    function automatic logic [7:0] char_for(int v);
        if (v < 26)
            return b64d_pkg::ASCII_UC_A + 8'(v);
        if (v < 52)
            return b64d_pkg::ASCII_LC_A + 8'(v - 26);
        if (v < 62)
            return b64d_pkg::ASCII_ZERO + 8'(v - 52);
        if (v == 62)
            return $urandom_range(0, 1) ? b64d_pkg::ASCII_MINUS : b64d_pkg::ASCII_PLUS;
        return $urandom_range(0, 1) ? b64d_pkg::ASCII_UNDER : b64d_pkg::ASCII_SLASH;
    endfunction

    // Mostly well-formed strings with random content, some noise and broken ends
    task automatic queue_random_strings();
        int         len;
        int         pick;
        bit         unterminated;
        logic [7:0] ch;
        while (char_beats.size() < RANDOM_CHARS + 25)
        begin
            len          = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
            unterminated = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    ch = 8'($urandom_range(0, 255));
                else if (pick < 10 || (i >= len - 2 && pick < 30))
                    ch = b64d_pkg::ASCII_EQUAL;
                else
                    ch = char_for($urandom_range(0, 63));
                queue_raw(ch, (i == len - 1) && !unterminated);
            end
        end
    endtask

    // Hold one character beat until the decoder takes it
    task automatic send_char(b64d_pkg::in_item_t c);
        push <= 1'b1;
        item <= c;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
    endtask

    initial
    begin
        int burst;
        int gap;

        // assert reset from the start
        rst_n <= 1'b0;

        // full groups over both alphabets' extremes, with and without the final flag
        queue_text("Az09", 1'b0);
        queue_text("-+_/", 1'b1);
        // pads inside a group, then a group of four pads
        queue_text("T=E=", 1'b0);
        queue_text("====", 1'b1);
        // strings that end partway through a group
        queue_text("TW", 1'b1);
        queue_text("TWE", 1'b1);
        // invalid character mid-string, dropped tail, then invalid on the last character
        queue_raw(8'hFF, 1'b0);
        queue_raw(8'h00, 1'b0);
        queue_text("A", 1'b1);
        queue_text("*", 1'b1);
        queue_random_strings();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // send in bursts with random gaps
        while (char_beats.size() != 0)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
            while (burst > 0 && char_beats.size() != 0)
            begin
                send_char(char_beats.pop_front());
                burst--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0 || char_beats.size() == 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // drain owed bytes, then allow for any stray beats
        while (tracker.due_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.due_bytes.size() == 0)
            $display("base64url_stream_decoder_test: clean");
        else
            $display("base64url_stream_decoder_test: errors");
        $finish;
    end

endmodule

>>> base64url_stream_decoder.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64url_stream_decoder.sv
design/b64d_checker.sv
dv/base64url_stream_decoder_test.sv
